FILE: sv/round_robin_cpu_scheduler_assert.svh
// Assertion macros for the round-robin scheduler RTL.
// No dependencies; each macro compiles to nothing when ASSERT_OFF is defined.
`ifndef ROUND_ROBIN_CPU_SCHEDULER_ASSERT_SVH
`define ROUND_ROBIN_CPU_SCHEDULER_ASSERT_SVH
`ifndef ASSERT_OFF
// Property checked while the block is out of reset.
`define RR_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Property checked on every edge, reset included.
`define RR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RR_ASSERT(lbl, clk, rstn, prop, msg)
`define RR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: sv/rrcs_pkg.sv
// Types, constants and controller/datapath interface structs for the scheduler.
// No dependencies.
package rrcs_pkg;

    localparam int MAX_PROCS = 16;
    localparam int IDX_W     = $clog2(MAX_PROCS);
    localparam int CNT_W     = IDX_W + 1;
    localparam int TIME_BITS = 16;
    localparam int Q_W       = 8;
    localparam int Q_RESET   = 4;

    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [Q_W-1:0]       quant_t;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_STEP  = 2'd1,
        OP_CLEAR = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_IDLE   = 2'd0,
        KIND_SLICE  = 2'd1,
        KIND_DONE   = 2'd2,
        KIND_REJECT = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN1,
        ST_DECIDE,
        ST_SCAN2,
        ST_FINISH,
        ST_REJECT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  do_load;
        logic  do_clear;
        logic  scan_init;
        logic  scan_step;
        logic  do_run;
        logic  do_finish;
        logic  emit;
        kind_t kind;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;
        logic fifo_empty;
        logic any_unadm;
        logic table_full;
        logic out_free;
    } dp_stat_t;

endpackage

FILE: sv/rrcs_ctrl.sv
// Scheduler controller: accepts items and sequences scans, dispatch and results.
// Depends on rrcs_pkg.
module rrcs_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [1:0]        opcode,
    input  rrcs_pkg::dp_stat_t stat,
    output rrcs_pkg::dp_cmd_t  cmd
);

    rrcs_pkg::state_t state_reg, state_next;
    logic accept;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rrcs_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == rrcs_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.kind   = rrcs_pkg::KIND_IDLE;
        unique case (state_reg)
            rrcs_pkg::ST_IDLE: begin
                if (accept) begin
                    priority if (opcode == rrcs_pkg::OP_LOAD) begin
                        if (stat.table_full) begin
                            state_next = rrcs_pkg::ST_REJECT;
                        end else begin
                            cmd.do_load = 1'b1;
                        end
                    end else if (opcode == rrcs_pkg::OP_CLEAR) begin
                        cmd.do_clear = 1'b1;
                    end else if (opcode == rrcs_pkg::OP_STEP) begin
                        cmd.scan_init = 1'b1;
                        state_next    = rrcs_pkg::ST_SCAN1;
                    end else begin
                        state_next = rrcs_pkg::ST_IDLE;
                    end
                end
            end
            rrcs_pkg::ST_SCAN1: begin
                if (stat.scan_done) begin
                    state_next = rrcs_pkg::ST_DECIDE;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            rrcs_pkg::ST_DECIDE: begin
                if (!stat.fifo_empty) begin
                    cmd.do_run    = 1'b1;
                    cmd.scan_init = 1'b1;
                    state_next    = rrcs_pkg::ST_SCAN2;
                end else if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = stat.any_unadm ? rrcs_pkg::KIND_IDLE : rrcs_pkg::KIND_DONE;
                    state_next = rrcs_pkg::ST_IDLE;
                end
            end
            rrcs_pkg::ST_SCAN2: begin
                if (stat.scan_done) begin
                    state_next = rrcs_pkg::ST_FINISH;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            rrcs_pkg::ST_FINISH: begin
                if (stat.out_free) begin
                    cmd.do_finish = 1'b1;
                    cmd.emit      = 1'b1;
                    cmd.kind      = rrcs_pkg::KIND_SLICE;
                    state_next    = rrcs_pkg::ST_IDLE;
                end
            end
            rrcs_pkg::ST_REJECT: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = rrcs_pkg::KIND_REJECT;
                    state_next = rrcs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rrcs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/rrcs_dpath.sv
// Scheduler datapath: process tables, ready queue, time, quantum and result register.
// Depends on rrcs_pkg and round_robin_cpu_scheduler_assert.svh.
`include "round_robin_cpu_scheduler_assert.svh"
module rrcs_dpath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  rrcs_pkg::dp_cmd_t     cmd,
    output rrcs_pkg::dp_stat_t    stat,
    input  rrcs_pkg::time_t       arrival_tick,
    input  rrcs_pkg::time_t       burst_length,
    input  logic                  cfg_wr_en,
    input  rrcs_pkg::quant_t      cfg_wr_data,
    input  logic                  m_tready,
    output logic                  out_valid,
    output rrcs_pkg::kind_t       out_kind,
    output rrcs_pkg::idx_t        out_index,
    output rrcs_pkg::time_t       out_start,
    output rrcs_pkg::quant_t      out_length,
    output logic                  out_finished,
    output rrcs_pkg::time_t       out_wait,
    output rrcs_pkg::time_t       out_turn
);

    localparam int MP = rrcs_pkg::MAX_PROCS;
    localparam int TB = rrcs_pkg::TIME_BITS;
    localparam int CW = rrcs_pkg::CNT_W;
    localparam int IW = rrcs_pkg::IDX_W;
    localparam int QW = rrcs_pkg::Q_W;

    rrcs_pkg::time_t  arr_mem   [MP];
    rrcs_pkg::time_t  burst_mem [MP];
    rrcs_pkg::time_t  rem_mem   [MP];
    rrcs_pkg::time_t  wait_mem  [MP];
    rrcs_pkg::time_t  last_mem  [MP];
    rrcs_pkg::idx_t   fifo_mem  [MP];
    logic [MP-1:0]    adm_reg;
    rrcs_pkg::idx_t   head_reg;
    rrcs_pkg::cnt_t   count_reg;
    rrcs_pkg::cnt_t   pcount_reg;
    rrcs_pkg::cnt_t   scan_reg;
    logic             unadm_reg;
    rrcs_pkg::time_t  now_reg;
    rrcs_pkg::quant_t quant_reg;
    rrcs_pkg::idx_t   p_reg;
    rrcs_pkg::time_t  start_reg;
    rrcs_pkg::quant_t run_reg;
    logic             out_valid_reg;

    rrcs_pkg::idx_t   rd_idx;
    rrcs_pkg::time_t  rd_arr, rd_burst, rd_rem, rd_wait, rd_last;
    logic             scan_push;
    logic             requeue;
    logic             push;
    rrcs_pkg::idx_t   push_idx;
    logic [CW:0]      tail_sum;
    rrcs_pkg::idx_t   tail;
    rrcs_pkg::quant_t q_eff;
    rrcs_pkg::time_t  run_len, gap, wait_sum, now_run, now_tick1;
    logic [TB:0]      wait_wide, run_wide, tick_wide;

    // Single read port into the process tables.
    always_comb begin
        priority if (cmd.scan_step) begin
            rd_idx = scan_reg[IW-1:0];
        end else if (cmd.do_run) begin
            rd_idx = fifo_mem[head_reg];
        end else begin
            rd_idx = p_reg;
        end
    end
    assign rd_arr   = arr_mem[rd_idx];
    assign rd_burst = burst_mem[rd_idx];
    assign rd_rem   = rem_mem[rd_idx];
    assign rd_wait  = wait_mem[rd_idx];
    assign rd_last  = last_mem[rd_idx];

    // Queue push: arrivals during a scan, or the preempted process at the end.
    assign scan_push = cmd.scan_step && !adm_reg[rd_idx] && (rd_arr <= now_reg);
    assign requeue   = cmd.do_finish && (rd_rem != '0);
    assign push      = scan_push || requeue;
    assign push_idx  = rd_idx;
    assign tail_sum  = {2'b0, head_reg} + {1'b0, count_reg};
    assign tail      = (tail_sum >= (CW+1)'(MP)) ? IW'(tail_sum - (CW+1)'(MP))
                                                 : tail_sum[IW-1:0];

    // Slice arithmetic: length, waiting gap and saturating time updates.
    assign q_eff     = (quant_reg == '0) ? QW'(1) : quant_reg;
    assign run_len   = (rd_rem < TB'(q_eff)) ? rd_rem : TB'(q_eff);
    assign gap       = (rd_burst == rd_rem) ? (now_reg - rd_arr) : (now_reg - rd_last);
    assign wait_wide = {1'b0, rd_wait} + {1'b0, gap};
    assign wait_sum  = wait_wide[TB] ? '1 : wait_wide[TB-1:0];
    assign run_wide  = {1'b0, now_reg} + {1'b0, run_len};
    assign now_run   = run_wide[TB] ? '1 : run_wide[TB-1:0];
    assign tick_wide = {1'b0, now_reg} + (TB+1)'(1);
    assign now_tick1 = tick_wide[TB] ? '1 : tick_wide[TB-1:0];

    // Process tables.
    always_ff @(posedge aclk) begin
        if (cmd.do_load) begin
            arr_mem[pcount_reg[IW-1:0]]   <= arrival_tick;
            burst_mem[pcount_reg[IW-1:0]] <= burst_length;
            rem_mem[pcount_reg[IW-1:0]]   <= burst_length;
            wait_mem[pcount_reg[IW-1:0]]  <= '0;
            last_mem[pcount_reg[IW-1:0]]  <= '0;
        end
        if (cmd.do_run) begin
            wait_mem[rd_idx] <= wait_sum;
            rem_mem[rd_idx]  <= rd_rem - run_len;
            last_mem[rd_idx] <= now_run;
        end
        if (push) begin
            fifo_mem[tail] <= push_idx;
        end
    end

    // Control counters, flags, time and quantum.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            adm_reg    <= '0;
            head_reg   <= '0;
            count_reg  <= '0;
            pcount_reg <= '0;
            scan_reg   <= '0;
            unadm_reg  <= 1'b0;
            now_reg    <= '0;
            quant_reg  <= QW'(rrcs_pkg::Q_RESET);
        end else begin
            if (cfg_wr_en) begin
                quant_reg <= cfg_wr_data;
            end
            if (cmd.do_clear) begin
                adm_reg    <= '0;
                head_reg   <= '0;
                count_reg  <= '0;
                pcount_reg <= '0;
                now_reg    <= '0;
            end
            if (cmd.do_load) begin
                adm_reg[pcount_reg[IW-1:0]] <= 1'b0;
                pcount_reg                  <= pcount_reg + CW'(1);
            end
            if (cmd.scan_init) begin
                scan_reg  <= '0;
                unadm_reg <= 1'b0;
            end
            if (cmd.scan_step) begin
                scan_reg <= scan_reg + CW'(1);
                if (scan_push) begin
                    adm_reg[rd_idx] <= 1'b1;
                end else if (!adm_reg[rd_idx]) begin
                    unadm_reg <= 1'b1;
                end
            end
            if (cmd.do_run) begin
                head_reg  <= (head_reg == IW'(MP - 1)) ? '0 : head_reg + IW'(1);
                count_reg <= count_reg - CW'(1);
                now_reg   <= now_run;
            end
            if (push) begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.emit && (cmd.kind == rrcs_pkg::KIND_IDLE)) begin
                now_reg <= now_tick1;
            end
        end
    end

    // Slice bookkeeping kept for the result.
    always_ff @(posedge aclk) begin
        if (cmd.do_run) begin
            p_reg     <= rd_idx;
            start_reg <= now_reg;
            run_reg   <= run_len[QW-1:0];
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_kind     <= cmd.kind;
            out_index    <= '0;
            out_start    <= now_reg;
            out_length   <= '0;
            out_finished <= 1'b0;
            out_wait     <= '0;
            out_turn     <= '0;
            if (cmd.kind == rrcs_pkg::KIND_SLICE) begin
                out_index  <= p_reg;
                out_start  <= start_reg;
                out_length <= run_reg;
                if (rd_rem == '0) begin
                    out_finished <= 1'b1;
                    out_wait     <= rd_wait;
                    out_turn     <= now_reg - rd_arr;
                end
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign stat.scan_done  = (scan_reg == pcount_reg);
    assign stat.fifo_empty = (count_reg == '0);
    assign stat.any_unadm  = unadm_reg;
    assign stat.table_full = (pcount_reg >= CW'(MP));
    assign stat.out_free   = !out_valid_reg || m_tready;

    // The queue never holds more entries than loaded processes.
    `RR_ASSERT(a_fifo_bound, aclk, aresetn, count_reg <= pcount_reg, "queue exceeds table")
    // A clear empties the time, table and queue.
    `RR_ASSERT(a_clear, aclk, aresetn, cmd.do_clear |=> (now_reg == '0 && count_reg == '0 && pcount_reg == '0), "clear incomplete")
    // A result is only written into a free output register.
    `RR_ASSERT(a_emit_free, aclk, aresetn, cmd.emit |-> (!out_valid_reg || m_tready), "result overwritten")
    // A slice is dispatched only from a nonempty queue.
    `RR_ASSERT(a_run_nonempty, aclk, aresetn, cmd.do_run |-> (count_reg != '0), "dispatch from empty queue")

endmodule

FILE: sv/round_robin_cpu_scheduler.sv
// Top level of the round-robin CPU scheduler with a time quantum.
// Depends on rrcs_pkg, rrcs_ctrl and rrcs_dpath.
//
//   Channel   Ports                      Moves
//   input     s_tvalid/s_tready/s_tuser  one command item (load, step, clear)
//   result    m_tvalid/m_tready/m_tuser  one event item (idle, slice, done, reject)
//   config    cfg_wr_en/cfg_wr_data      time quantum write
//
// Load, clear and ignored opcodes return the block straight to idle, a rejected load once
// its reject result is written. A step that runs a slice makes two passes over the table
// for arrivals, before and after dispatch, an idle or done step one: one-entry-per-cycle
// passes, set by the single table read port.
// Reset (aresetn low, synchronous) empties the table, queue and time and sets
// the quantum to 4. A stalled result holds only the final result write, with the requeue of
// a preempted process; the scans run on regardless.
module round_robin_cpu_scheduler (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // arrival_tick[15:0], burst_length[31:16]
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // proc_index[3:0], slice_start[19:4], slice_length[27:20],
                                   // proc_finished[28], wait_total[44:29], turnaround[60:45]
    output logic [1:0]  m_tuser,   // event_kind[1:0]
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data
);

    rrcs_pkg::dp_cmd_t cmd;
    rrcs_pkg::dp_stat_t stat;
    rrcs_pkg::kind_t   out_kind;
    rrcs_pkg::idx_t    out_index;
    rrcs_pkg::time_t   out_start, out_wait, out_turn;
    rrcs_pkg::quant_t  out_length;
    logic              out_finished;

    rrcs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .opcode   (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    rrcs_dpath u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .arrival_tick (s_tdata[15:0]),
        .burst_length (s_tdata[31:16]),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .m_tready     (m_tready),
        .out_valid    (m_tvalid),
        .out_kind     (out_kind),
        .out_index    (out_index),
        .out_start    (out_start),
        .out_length   (out_length),
        .out_finished (out_finished),
        .out_wait     (out_wait),
        .out_turn     (out_turn)
    );

    // Pack the result item.
    assign m_tuser = out_kind;
    assign m_tdata = {3'b000, out_turn, out_wait, out_finished, out_length, out_start, out_index};

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the round-robin CPU scheduler: directed and random command items,
// with a predictor of the scheduling decisions kept in a small scoreboard class.
// Depends on rrcs_pkg and round_robin_cpu_scheduler.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 45;
    localparam int PHASE_ITEMS = 215;

    // One predicted or observed event.
    typedef struct {
        rrcs_pkg::kind_t  kind;
        rrcs_pkg::idx_t   idx;
        rrcs_pkg::time_t  start;
        rrcs_pkg::quant_t len;
        bit               fin;
        rrcs_pkg::time_t  wt;
        rrcs_pkg::time_t  ta;
    } sched_event_t;

    // Scheduler predictor and store of expected events.
    class sched_scoreboard;
        rrcs_pkg::time_t  arr_t[rrcs_pkg::MAX_PROCS];
        rrcs_pkg::time_t  burst_t[rrcs_pkg::MAX_PROCS];
        rrcs_pkg::time_t  rem_t[rrcs_pkg::MAX_PROCS];
        rrcs_pkg::time_t  wait_t[rrcs_pkg::MAX_PROCS];
        rrcs_pkg::time_t  last_t[rrcs_pkg::MAX_PROCS];
        bit               admitted[rrcs_pkg::MAX_PROCS];
        int               ready_q[$];
        int               loaded;
        rrcs_pkg::time_t  now_t;
        rrcs_pkg::quant_t quantum;
        sched_event_t     expected_events[$];
        int               errors;

        function new();
            quantum = rrcs_pkg::quant_t'(rrcs_pkg::Q_RESET);
            errors = 0;
            clear_table();
        endfunction

        function void clear_table();
            ready_q.delete();
            loaded = 0;
            now_t = '0;
            foreach (admitted[i]) admitted[i] = 0;
        endfunction

        function rrcs_pkg::time_t sat(int unsigned a, int unsigned b);
            int unsigned s;
            s = a + b;
            return (s > 32'hFFFF) ? 16'hFFFF : rrcs_pkg::time_t'(s);
        endfunction

        function void admit();
            for (int i = 0; i < loaded; i++) begin
                if (!admitted[i] && arr_t[i] <= now_t) begin
                    admitted[i] = 1;
                    ready_q.insert(ready_q.size(), i);
                end
            end
        endfunction

        function bit any_unadmitted();
            for (int i = 0; i < loaded; i++)
                if (!admitted[i]) return 1;
            return 0;
        endfunction

        function bit all_done();
            return ready_q.size() == 0 && !any_unadmitted();
        endfunction

        // Work out what one accepted command item produces.
        function void note_command(logic [1:0] op, rrcs_pkg::time_t a, rrcs_pkg::time_t b);
            sched_event_t e;
            int p;
            int unsigned q, run, gap;
            e = '{rrcs_pkg::KIND_IDLE, '0, now_t, '0, 1'b0, '0, '0};
            case (op)
                rrcs_pkg::OP_LOAD: begin
                    if (loaded >= rrcs_pkg::MAX_PROCS) begin
                        e.kind = rrcs_pkg::KIND_REJECT;
                        expected_events.insert(expected_events.size(), e);
                    end else begin
                        arr_t[loaded] = a;
                        burst_t[loaded] = b;
                        rem_t[loaded] = b;
                        wait_t[loaded] = '0;
                        last_t[loaded] = '0;
                        admitted[loaded] = 0;
                        loaded++;
                    end
                end
                rrcs_pkg::OP_CLEAR: clear_table();
                rrcs_pkg::OP_STEP: begin
                    admit();
                    if (ready_q.size() == 0) begin
                        if (!any_unadmitted()) begin
                            e.kind = rrcs_pkg::KIND_DONE;
                        end else begin
                            e.kind = rrcs_pkg::KIND_IDLE;
                            now_t = sat(now_t, 1);
                        end
                    end else begin
                        p = ready_q.pop_front();
                        q = (quantum == 0) ? 1 : quantum;
                        run = (rem_t[p] < q) ? rem_t[p] : q;
                        gap = (burst_t[p] == rem_t[p]) ? now_t - arr_t[p] : now_t - last_t[p];
                        wait_t[p] = sat(wait_t[p], gap);
                        e.kind = rrcs_pkg::KIND_SLICE;
                        e.idx = rrcs_pkg::idx_t'(p);
                        e.len = rrcs_pkg::quant_t'(run);
                        now_t = sat(now_t, run);
                        rem_t[p] = rrcs_pkg::time_t'(rem_t[p] - run);
                        last_t[p] = now_t;
                        admit();
                        if (rem_t[p] > 0) begin
                            ready_q.insert(ready_q.size(), p);
                        end else begin
                            e.fin = 1;
                            e.wt = wait_t[p];
                            e.ta = now_t - arr_t[p];
                        end
                    end
                    expected_events.insert(expected_events.size(), e);
                end
                default: ;
            endcase
        endfunction

        task report(string what, int unsigned got, int unsigned want);
            $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
            errors++;
        endtask

        // Compare one accepted result item with the oldest expectation.
        task check_result(logic [1:0] kind, logic [63:0] d);
            sched_event_t e;
            if (expected_events.size() == 0) begin
                report("unexpected result, kind", kind, 0);
                return;
            end
            e = expected_events.pop_front();
            if (kind !== e.kind) report("event_kind", kind, e.kind);
            if (d[3:0] !== e.idx) report("proc_index", d[3:0], e.idx);
            if (d[19:4] !== e.start) report("slice_start", d[19:4], e.start);
            if (d[27:20] !== e.len) report("slice_length", d[27:20], e.len);
            if (d[28] !== e.fin) report("proc_finished", d[28], e.fin);
            if (d[44:29] !== e.wt) report("wait_total", d[44:29], e.wt);
            if (d[60:45] !== e.ta) report("turnaround", d[60:45], e.ta);
        endtask
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_wr_en = 0;
    logic [7:0]  cfg_wr_data = '0;

    sched_scoreboard sb = new();
    int  send_idle = 0;
    int  recv_idle = 0;
    bit  recv_hold = 0;
    int  quiet_cycles = 0;
    int  items_sent = 0;

    round_robin_cpu_scheduler dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    // Receiver: random back-pressure, or a long hold-off on request.
    always @(negedge aclk) begin
        m_tready <= !recv_hold && ($urandom_range(99) >= recv_idle);
    end

    // Result checking and the stall watchdog.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one command item and wait until it is accepted.
    task send(logic [1:0] op, rrcs_pkg::time_t a, rrcs_pkg::time_t b);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 0;
            @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= op;
        s_tdata <= {b, a};
        do @(posedge aclk); while (!s_tready);
        sb.note_command(op, a, b);
        items_sent++;
    endtask

    // Let all results drain, then the block settle, then write the quantum.
    task set_quantum(rrcs_pkg::quant_t q);
        @(negedge aclk);
        s_tvalid <= 0;
        while (sb.expected_events.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
        cfg_wr_en <= 1;
        cfg_wr_data <= q;
        @(posedge aclk);
        sb.quantum = q;
        @(negedge aclk);
        cfg_wr_en <= 0;
    endtask

    function rrcs_pkg::time_t rand_arrival();
        return ($urandom_range(9) == 0) ? rrcs_pkg::time_t'($urandom)
                                        : rrcs_pkg::time_t'($urandom_range(40));
    endfunction

    function rrcs_pkg::time_t rand_burst();
        return ($urandom_range(9) == 0) ? rrcs_pkg::time_t'($urandom_range(65535, 1))
                                        : rrcs_pkg::time_t'($urandom_range(12, 1));
    endfunction

    // One workload: clear, load processes, up to 45 items, mostly steps; may end once done.
    task run_workload();
        int n, steps;
        send(rrcs_pkg::OP_CLEAR, rrcs_pkg::time_t'($urandom), rrcs_pkg::time_t'($urandom));
        n = ($urandom_range(7) == 0) ? $urandom_range(18, 14) : $urandom_range(8, 1);
        for (int i = 0; i < n; i++) send(rrcs_pkg::OP_LOAD, rand_arrival(), rand_burst());
        steps = 0;
        while (steps < 45 && !(sb.all_done() && $urandom_range(2) == 0)) begin
            if ($urandom_range(19) == 0)
                send(2'($urandom_range(3)), rrcs_pkg::time_t'($urandom),
                     rrcs_pkg::time_t'($urandom));
            else
                send(rrcs_pkg::OP_STEP, rrcs_pkg::time_t'($urandom),
                     rrcs_pkg::time_t'($urandom));
            steps++;
        end
    endtask

    initial begin
        rrcs_pkg::quant_t quanta[6];
        quanta = '{8'd1, 8'd255, 8'd0, 8'd2, rrcs_pkg::quant_t'($urandom_range(255, 1)), 8'd7};

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        // Directed: empty table, zero burst, idle ticks, unused opcode, clear.
        send(rrcs_pkg::OP_STEP, 16'hFFFF, 16'hFFFF);
        send(rrcs_pkg::OP_LOAD, 16'd0, 16'd5);
        send(rrcs_pkg::OP_LOAD, 16'd2, 16'd0);
        send(rrcs_pkg::OP_LOAD, 16'd0, 16'd3);
        send(rrcs_pkg::OP_LOAD, 16'd20, 16'd1);
        repeat (14) send(rrcs_pkg::OP_STEP, 16'h0000, 16'h0000);
        send(OP_UNUSED, 16'hFFFF, 16'hFFFF);
        send(rrcs_pkg::OP_CLEAR, 16'h0000, 16'h0000);
        send(rrcs_pkg::OP_STEP, 16'h0000, 16'h0000);

        for (int ph = 0; ph < 6; ph++) begin
            set_quantum(quanta[ph]);
            send_idle = (ph < 2) ? 24 : (ph < 4) ? 50 : 0;
            recv_idle = (ph < 2) ? 50 : (ph < 4) ? 24 : 0;
            // A long receiver hold-off while the sender keeps offering items.
            if (ph == 4) fork
                begin
                    recv_hold = 1;
                    repeat (400) @(posedge aclk);
                    recv_hold = 0;
                end
            join_none
            // Time and waiting saturation with the longest slices.
            if (quanta[ph] == 8'd255) begin
                send(rrcs_pkg::OP_CLEAR, 16'h0000, 16'h0000);
                send(rrcs_pkg::OP_LOAD, 16'd0, 16'hFFFF);
                send(rrcs_pkg::OP_LOAD, 16'hFFFF, 16'd1);
                send(rrcs_pkg::OP_LOAD, 16'd1, 16'd300);
                while (!sb.all_done()) send(rrcs_pkg::OP_STEP, 16'h0000, 16'h0000);
                send(rrcs_pkg::OP_STEP, 16'h0000, 16'h0000);
            end
            items_sent = 0;
            while (items_sent < PHASE_ITEMS) run_workload();
        end

        @(negedge aclk);
        s_tvalid <= 0;
        while (sb.expected_events.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
